// ===== hdl/pidc_pkg.sv =====
package pidc_pkg;

   // field and state widths
   localparam int DATA_W     = 32;
   localparam int DT_W       = 16;
   localparam int LIMIT_W    = 31;
   localparam int INT_FRAC_W = 16;
   localparam int INTEG_W    = 48;
   localparam int DERR_W     = 33;
   localparam int ISUM_W     = 50;
   localparam int SUM_W      = 83;
   localparam int CSR_IDX_W  = 3;

   // product widths of the serial multipliers
   localparam int DTMUL_W = DATA_W + DT_W + 1;
   localparam int PMUL_W  = DATA_W + DATA_W;
   localparam int IMUL_W  = INTEG_W + DATA_W;
   localparam int DMUL_W  = DERR_W + DATA_W;

   localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KP             = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KI             = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KD_OVER_DT     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DT_STEP        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEGRAL_LIMIT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SETPOINT_HIGH  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SETPOINT_LOW   = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_ERR,
      ST_DERR,
      ST_IMUL,
      ST_ICLAMP,
      ST_GSTART,
      ST_GMUL,
      ST_SUM1,
      ST_SUM2,
      ST_TRUNC,
      ST_DONE
   } state_type;

endpackage

// ===== hdl/pidc_ser_mul.sv =====
// Serial-parallel signed multiplier: one multiplier bit per cycle, LSB first.
// The top bit of the multiplier carries negative weight.
module pidc_ser_mul #(
   parameter int MD_W = 32,
   parameter int MR_W = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [MD_W-1:0]        multiplicand,
   input  logic [MR_W-1:0]        multiplier,
   output logic                   done,
   output logic [MD_W+MR_W-1:0]   product
);

   localparam int CNT_W = $clog2(MR_W + 1);
   localparam int SW    = MD_W + 2;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [MD_W-1:0]  md_ff, md_in;
   logic [MR_W-1:0]  mb_ff, mb_in;
   logic [MD_W:0]    hi_ff, hi_in;
   logic [MR_W-1:0]  lo_ff, lo_in;

   logic [SW-1:0] md_ext;
   logic [SW-1:0] addend;
   logic [SW-1:0] psum;
   logic          last;

   assign last   = (cnt_ff == CNT_W'(1));
   assign md_ext = {{2{md_ff[MD_W-1]}}, md_ff};
   assign addend = !mb_ff[0] ? '0 : (last ? (~md_ext + SW'(1)) : md_ext);
   assign psum   = {hi_ff[MD_W], hi_ff} + addend;

   always_comb begin
      cnt_in = cnt_ff;
      md_in  = md_ff;
      mb_in  = mb_ff;
      hi_in  = hi_ff;
      lo_in  = lo_ff;
      if (start) begin
         cnt_in = CNT_W'(MR_W);
         md_in  = multiplicand;
         mb_in  = multiplier;
         hi_in  = '0;
         lo_in  = '0;
      end else if (cnt_ff != '0) begin
         // add, then shift the partial product right one place
         cnt_in = cnt_ff - CNT_W'(1);
         mb_in  = {1'b0, mb_ff[MR_W-1:1]};
         hi_in  = psum[SW-1:1];
         lo_in  = {psum[0], lo_ff[MR_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      md_ff <= md_in;
      mb_ff <= mb_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign done    = (cnt_ff == '0);
   assign product = {hi_ff[MD_W-1:0], lo_ff};

endmodule

// ===== hdl/pid_controller_step_top.sv =====
// Channel  Direction  Handshake                 Payload
// req      in         req_tvalid / req_tready   tdata: setpoint, measurement; tuser: command
// rsp      out        rsp_tvalid / rsp_tready   tdata: drive; tuser: drive_saturated
// csr      in         csr_valid / csr_ready     csr_index, csr_wdata
//
// One item is processed at a time: a new item is taken only once the previous result is
// registered. The bit-serial multipliers set the pace: first error * dt_step (17 multiplier
// bits), then the three gain products running side by side (32 bits each), plus single
// steps for clamping, error, error difference, integral clamp, multiplier start, the two
// sums, truncation and the output load.
// Synchronous active-high reset clears the integral, the previous error, the registers
// (to their documented reset values) and the control state.
// A result waits in the output register while the next item is taken in; the pipeline
// holds in its last step only when that register is still full.
module pid_controller_step_top
   import pidc_pkg::*;
#(
   parameter int GAIN_FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   // input item stream
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [63:0]          req_tdata,   // [31:0] setpoint, [63:32] measurement
   input  logic                 req_tuser,   // [0] command
   // result stream
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,   // [31:0] drive
   output logic                 rsp_tuser,   // [0] drive_saturated
   // register write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   // fraction bits of the exact three-term sum, and width of the truncated quotient
   localparam int FB = GAIN_FRAC_BITS + INT_FRAC_W;
   localparam int QW = SUM_W - FB;

   // configuration registers
   logic signed [DATA_W-1:0] kp_ff, kp_in;
   logic signed [DATA_W-1:0] ki_ff, ki_in;
   logic signed [DATA_W-1:0] kd_ff, kd_in;
   logic [DT_W-1:0]          dt_ff, dt_in;
   logic [LIMIT_W-1:0]       ilim_ff, ilim_in;
   logic signed [DATA_W-1:0] sph_ff, sph_in;
   logic signed [DATA_W-1:0] spl_ff, spl_in;

   // control and controller state
   state_type                 state_ff, state_in;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic signed [DATA_W-1:0]  prev_ff, prev_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // per-item working registers
   logic                      cmd_ff, cmd_in;
   logic signed [DATA_W-1:0]  sp_ff, sp_in;
   logic signed [DATA_W-1:0]  meas_ff, meas_in;
   logic signed [DATA_W-1:0]  err_ff, err_in;
   logic                      esat_ff, esat_in;
   logic [DERR_W-1:0]         derr_ff, derr_in;
   logic [ISUM_W-1:0]         isum_ff, isum_in;
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic [QW-1:0]             q_ff, q_in;
   logic [DATA_W-1:0]         drive_ff, drive_in;
   logic                      dsat_ff, dsat_in;

   // multiplier hookup
   logic                imul_start, gmul_start;
   logic                dtm_done, pm_done, im_done, dm_done;
   logic [DTMUL_W-1:0]  dt_prod;
   logic [PMUL_W-1:0]   p_prod;
   logic [IMUL_W-1:0]   i_prod;
   logic [DMUL_W-1:0]   d_prod;

   // combinational helpers
   logic [DATA_W:0]     ediff;
   logic                esat;
   logic [ISUM_W-1:0]   lim_pos, lim_neg;
   logic [SUM_W-1:0]    term_p, term_i, term_d;
   logic                tcorr;
   logic [QW-DATA_W:0]  q_top;
   logic                q_fits;
   logic                out_load;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = drive_ff;
   assign rsp_tuser  = dsat_ff;

   assign imul_start = (state_ff == ST_DERR);
   assign gmul_start = (state_ff == ST_GSTART);

   // error * dt_step, dt_step taken as a non-negative 17-bit multiplier
   pidc_ser_mul #(.MD_W(DATA_W), .MR_W(DT_W + 1)) u_dt_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (imul_start),
      .multiplicand (err_ff),
      .multiplier   ({1'b0, dt_ff}),
      .done         (dtm_done),
      .product      (dt_prod)
   );

   pidc_ser_mul #(.MD_W(DATA_W), .MR_W(DATA_W)) u_p_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (gmul_start),
      .multiplicand (err_ff),
      .multiplier   (kp_ff),
      .done         (pm_done),
      .product      (p_prod)
   );

   pidc_ser_mul #(.MD_W(INTEG_W), .MR_W(DATA_W)) u_i_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (gmul_start),
      .multiplicand (integ_ff),
      .multiplier   (ki_ff),
      .done         (im_done),
      .product      (i_prod)
   );

   pidc_ser_mul #(.MD_W(DERR_W), .MR_W(DATA_W)) u_d_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (gmul_start),
      .multiplicand (derr_ff),
      .multiplier   (kd_ff),
      .done         (dm_done),
      .product      (d_prod)
   );

   // register writes
   always_comb begin
      kp_in   = kp_ff;
      ki_in   = ki_ff;
      kd_in   = kd_ff;
      dt_in   = dt_ff;
      ilim_in = ilim_ff;
      sph_in  = sph_ff;
      spl_in  = spl_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_KP:             kp_in   = csr_wdata;
            CSR_KI:             ki_in   = csr_wdata;
            CSR_KD_OVER_DT:     kd_in   = csr_wdata;
            CSR_DT_STEP:        dt_in   = csr_wdata[DT_W-1:0];
            CSR_INTEGRAL_LIMIT: ilim_in = csr_wdata[LIMIT_W-1:0];
            CSR_SETPOINT_HIGH:  sph_in  = csr_wdata;
            CSR_SETPOINT_LOW:   spl_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   // error, saturated to 32 bits
   assign ediff = {sp_ff[DATA_W-1], sp_ff} - {meas_ff[DATA_W-1], meas_ff};
   assign esat  = (ediff[DATA_W] != ediff[DATA_W-1]);

   // integral clamp bounds, integral_limit whole units in Q31.16
   assign lim_pos = {{(ISUM_W - LIMIT_W - INT_FRAC_W){1'b0}}, ilim_ff, {INT_FRAC_W{1'b0}}};
   assign lim_neg = ~lim_pos + ISUM_W'(1);

   // align all three terms to FB fraction bits
   assign term_p = {{(SUM_W - PMUL_W - INT_FRAC_W){p_prod[PMUL_W-1]}}, p_prod,
                    {INT_FRAC_W{1'b0}}};
   assign term_i = {{(SUM_W - IMUL_W){i_prod[IMUL_W-1]}}, i_prod};
   assign term_d = {{(SUM_W - DMUL_W - INT_FRAC_W){d_prod[DMUL_W-1]}}, d_prod,
                    {INT_FRAC_W{1'b0}}};

   // truncation toward zero: floor, plus one when negative with fraction left over
   assign tcorr = sum_ff[SUM_W-1] & (|sum_ff[FB-1:0]);

   assign q_top    = q_ff[QW-1:DATA_W-1];
   assign q_fits   = (&q_top) | ~(|q_top);
   assign out_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      integ_in     = integ_ff;
      prev_in      = prev_ff;
      cmd_in       = cmd_ff;
      sp_in        = sp_ff;
      meas_in      = meas_ff;
      err_in       = err_ff;
      esat_in      = esat_ff;
      derr_in      = derr_ff;
      isum_in      = isum_ff;
      sum_in       = sum_ff;
      q_in         = q_ff;
      drive_in     = drive_ff;
      dsat_in      = dsat_ff;
      rsp_valid_in = rsp_valid_ff;

      // drop the result once the consumer takes it
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = req_tuser;
               sp_in    = req_tdata[DATA_W-1:0];
               meas_in  = req_tdata[2*DATA_W-1:DATA_W];
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            // the upper limit is tested first, so when the limits cross it wins only for a setpoint above it
            if (sp_ff > sph_ff) begin
               sp_in = sph_ff;
            end else if (sp_ff < spl_ff) begin
               sp_in = spl_ff;
            end
            if (cmd_ff) begin
               integ_in = '0;
               prev_in  = '0;
            end
            state_in = ST_ERR;
         end
         ST_ERR: begin
            esat_in = esat;
            if (esat) begin
               err_in = ediff[DATA_W] ? S32_MIN : S32_MAX;
            end else begin
               err_in = ediff[DATA_W-1:0];
            end
            state_in = ST_DERR;
         end
         ST_DERR: begin
            derr_in  = {err_ff[DATA_W-1], err_ff} - {prev_ff[DATA_W-1], prev_ff};
            prev_in  = err_ff;
            state_in = ST_IMUL;
         end
         ST_IMUL: begin
            if (dtm_done) begin
               isum_in = {{(ISUM_W - INTEG_W){integ_ff[INTEG_W-1]}}, integ_ff}
                       + {{(ISUM_W - DTMUL_W){dt_prod[DTMUL_W-1]}}, dt_prod};
               state_in = ST_ICLAMP;
            end
         end
         ST_ICLAMP: begin
            if ($signed(isum_ff) > $signed(lim_pos)) begin
               integ_in = lim_pos[INTEG_W-1:0];
            end else if ($signed(isum_ff) < $signed(lim_neg)) begin
               integ_in = lim_neg[INTEG_W-1:0];
            end else begin
               integ_in = isum_ff[INTEG_W-1:0];
            end
            state_in = ST_GSTART;
         end
         ST_GSTART: begin
            state_in = ST_GMUL;
         end
         ST_GMUL: begin
            if (pm_done && im_done && dm_done) begin
               state_in = ST_SUM1;
            end
         end
         ST_SUM1: begin
            sum_in   = term_p + term_i;
            state_in = ST_SUM2;
         end
         ST_SUM2: begin
            sum_in   = sum_ff + term_d;
            state_in = ST_TRUNC;
         end
         ST_TRUNC: begin
            q_in     = sum_ff[SUM_W-1:FB] + QW'(tcorr);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (out_load) begin
               if (q_fits) begin
                  drive_in = q_ff[DATA_W-1:0];
               end else begin
                  drive_in = q_ff[QW-1] ? S32_MIN : S32_MAX;
               end
               dsat_in      = esat_ff | ~q_fits;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff        <= '0;
         ki_ff        <= '0;
         kd_ff        <= '0;
         dt_ff        <= '0;
         ilim_ff      <= {LIMIT_W{1'b1}};
         sph_ff       <= S32_MAX;
         spl_ff       <= S32_MIN;
         state_ff     <= ST_IDLE;
         integ_ff     <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         kp_ff        <= kp_in;
         ki_ff        <= ki_in;
         kd_ff        <= kd_in;
         dt_ff        <= dt_in;
         ilim_ff      <= ilim_in;
         sph_ff       <= sph_in;
         spl_ff       <= spl_in;
         state_ff     <= state_in;
         integ_ff     <= integ_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff   <= cmd_in;
      sp_ff    <= sp_in;
      meas_ff  <= meas_in;
      err_ff   <= err_in;
      esat_ff  <= esat_in;
      derr_ff  <= derr_in;
      isum_ff  <= isum_in;
      sum_ff   <= sum_in;
      q_ff     <= q_in;
      drive_ff <= drive_in;
      dsat_ff  <= dsat_in;
   end

endmodule
